FILE: design/tict_pkg.sv
// shared constants for the incircle touch point pipeline
// no dependencies

package tict_pkg;

  // extra fraction bits carried through the side lengths
  localparam int unsigned GUARD = 6;

  // number of coordinate fields per triangle and per result
  localparam int unsigned NUM_COORDS = 6;

endpackage

FILE: design/tict_isqrt.sv
// pipelined integer square root, one root bit per register stage
// depends on nothing

module tict_isqrt #(
  parameter int unsigned RAD_W = 63
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [RAD_W-1:0]             rad_i,
  output logic [(RAD_W+1)/2-1:0]       root_o
);

  localparam int unsigned QW  = (RAD_W + 1) / 2;
  localparam int unsigned PW  = 2 * QW;
  localparam int unsigned RMW = QW + 2;

  logic [PW-1:0]  rad_q  [QW+1];
  logic [RMW-1:0] rem_q  [QW+1];
  logic [QW-1:0]  root_q [QW+1];

  assign rad_q[0]  = PW'(rad_i);
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic [RMW-1:0] rem_d;
    logic [QW-1:0]  root_d;

    always_comb begin
      rem_sh = RMW'({rem_q[k], rad_q[k][PW-1 -: 2]});
      trial  = RMW'({root_q[k], 2'b01});
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[k][QW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[k][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1]  <= {rad_q[k][PW-3:0], 2'b00};
        rem_q[k+1]  <= rem_d;
        root_q[k+1] <= root_d;
      end
    end
  end

  assign root_o = root_q[QW];

endmodule

FILE: design/tict_div.sv
// pipelined restoring divider, one quotient bit per register stage
// depends on nothing; numerator must be below den << QUO_W

module tict_div #(
  parameter int unsigned NUM_W = 59,
  parameter int unsigned DEN_W = 33,
  parameter int unsigned QUO_W = 27
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_q [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];

  assign rem_q[0] = num_i;
  assign den_q[0] = den_i;
  assign quo_q[0] = '0;

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] den_sh;
    logic [NUM_W-1:0] rem_d;
    logic             bit_d;

    always_comb begin
      rem_ext = CMP_W'(rem_q[i]);
      den_sh  = CMP_W'(den_q[i]) << (QUO_W - 1 - i);
      bit_d   = (rem_ext >= den_sh);
      rem_d   = bit_d ? NUM_W'(rem_ext - den_sh) : rem_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= rem_d;
        den_q[i+1] <= den_q[i];
        quo_q[i+1] <= QUO_W'({quo_q[i], bit_d});
      end
    end
  end

  assign quo_o = quo_q[QUO_W];

endmodule

FILE: design/triangle_incircle_touch_points.sv
// Incircle touch points of a triangle on AB, BC and CA, fully pipelined.
// Input channel s_axis: one transfer is one triangle (ax, ay, bx, by_coord, cx, cy).
// Output channel m_axis: one transfer per triangle, the three touch points in
// tdata and the degenerate flag in tuser. Coordinates are signed fixed point;
// the fraction width does not change the arithmetic.
// The pipeline registers, in order:
// three front stages (differences, squares, radicands), one stage per root
// bit of the three square roots, tangent and multiply stages, one stage per
// quotient bit of the six dividers, and the saturating output register.
// Throughput is one triangle per cycle unless m_axis holds the pipeline.
// A triangle with two equal vertices gives tuser 1 and all-zero points;
// results outside the coordinate range are clamped.
// Reset clears every valid bit; the pipeline is then empty and ready.
// When m_axis_tready_i is low with a result waiting, the whole pipeline holds
// and s_axis_tready_o drops; nothing is lost or repeated.
// Depends on tict_pkg, tict_isqrt and tict_div.

module triangle_incircle_touch_points #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid_i,
  output logic                                         s_axis_tready_o,
  // ax, ay, bx, by_coord, cx, cy
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]           s_axis_tdata_i,
  output logic                                         m_axis_tvalid_o,
  input  logic                                         m_axis_tready_i,
  // touch_ab_x, touch_ab_y, touch_bc_x, touch_bc_y, touch_ca_x, touch_ca_y
  output logic [((6*COORD_WIDTH+7)/8)*8-1:0]           m_axis_tdata_o,
  // status
  output logic                                         m_axis_tuser_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned NC   = tict_pkg::NUM_COORDS;
  localparam int unsigned DW   = CW + 1;
  localparam int unsigned SQW  = 2 * DW;
  localparam int unsigned RW   = 2 * DW + 1 + 2 * tict_pkg::GUARD;
  localparam int unsigned QW   = (RW + 1) / 2;
  localparam int unsigned MTW  = QW + 1;
  localparam int unsigned TW   = QW + 2;
  localparam int unsigned NW   = DW + QW + 2;
  localparam int unsigned DENW = QW + 1;
  localparam int unsigned QB   = CW + 3;
  localparam int unsigned SW   = CW + 5;
  localparam int unsigned LAT  = 6 + QW + QB;
  localparam int unsigned SQL_W = NC * CW + NC * DW;
  localparam int unsigned DVL_W = 1 + NC + 4 * CW;

  logic [LAT-1:0] vld_q;
  logic           en;

  assign en = ~vld_q[LAT-1] | m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  // stage 1: coordinates and side differences
  logic signed [CW-1:0] cin [NC];
  logic signed [DW-1:0] d1_d [NC];
  logic signed [CW-1:0] c1_q [NC];
  logic signed [DW-1:0] d1_q [NC];

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      cin[k] = s_axis_tdata_i[k*CW +: CW];
    end
    d1_d[0] = DW'(cin[2]) - DW'(cin[0]);
    d1_d[1] = DW'(cin[3]) - DW'(cin[1]);
    d1_d[2] = DW'(cin[4]) - DW'(cin[2]);
    d1_d[3] = DW'(cin[5]) - DW'(cin[3]);
    d1_d[4] = DW'(cin[4]) - DW'(cin[0]);
    d1_d[5] = DW'(cin[5]) - DW'(cin[1]);
  end

  // stage 2: squares
  logic [DW-1:0]        mg1 [NC];
  logic [SQW-1:0]       sq2_q [NC];
  logic signed [CW-1:0] c2_q [NC];
  logic signed [DW-1:0] d2_q [NC];

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      mg1[k] = d1_q[k][DW-1] ? DW'(-d1_q[k]) : DW'(d1_q[k]);
    end
  end

  // stage 3: guarded radicands
  logic [RW-1:0]        rad3_q [3];
  logic signed [CW-1:0] c3_q [NC];
  logic signed [DW-1:0] d3_q [NC];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NC; k++) begin
        c1_q[k]  <= cin[k];
        d1_q[k]  <= d1_d[k];
        sq2_q[k] <= mg1[k] * mg1[k];
        c2_q[k]  <= c1_q[k];
        d2_q[k]  <= d1_q[k];
        c3_q[k]  <= c2_q[k];
        d3_q[k]  <= d2_q[k];
      end
      for (int s = 0; s < 3; s++) begin
        rad3_q[s] <= (RW'(sq2_q[2*s]) + RW'(sq2_q[2*s+1])) << (2 * tict_pkg::GUARD);
      end
    end
  end

  // square roots, with coordinates and differences delayed alongside
  logic [QW-1:0]    len [3];
  logic [SQL_W-1:0] sql_in;
  logic [SQL_W-1:0] sql_q [QW];

  for (genvar s = 0; s < 3; s++) begin : g_sqrt
    tict_isqrt #(
      .RAD_W (RW)
    ) u_isqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (rad3_q[s]),
      .root_o (len[s])
    );
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      sql_in[k*CW +: CW]         = c3_q[k];
      sql_in[NC*CW + k*DW +: DW] = d3_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sql_q[0] <= sql_in;
      for (int k = 1; k < QW; k++) begin
        sql_q[k] <= sql_q[k-1];
      end
    end
  end

  // stage 4: tangent sums, magnitudes and signs
  logic signed [CW-1:0] cs [NC];
  logic signed [DW-1:0] ds [NC];
  logic signed [TW-1:0] t4 [2];
  logic [QW-1:0]        len4_q [3];
  logic [MTW-1:0]       mt4_q [2];
  logic                 st4_q [2];
  logic [DW-1:0]        md4_q [NC];
  logic                 sd4_q [NC];
  logic                 deg4_q;
  logic signed [CW-1:0] base4_q [4];

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      cs[k] = sql_q[QW-1][k*CW +: CW];
      ds[k] = sql_q[QW-1][NC*CW + k*DW +: DW];
    end
    t4[0] = TW'(len[0]) + TW'(len[2]) - TW'(len[1]);
    t4[1] = TW'(len[0]) + TW'(len[1]) - TW'(len[2]);
  end

  // stage 5: numerators and divisors
  logic [NW-1:0]   num5_q [NC];
  logic [DENW-1:0] den5_q [3];
  logic            neg5_q [NC];
  logic            deg5_q;
  logic signed [CW-1:0] base5_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < 3; s++) begin
        len4_q[s] <= len[s];
        den5_q[s] <= {len4_q[s], 1'b0};
      end
      for (int j = 0; j < 2; j++) begin
        st4_q[j] <= t4[j][TW-1];
        mt4_q[j] <= t4[j][TW-1] ? MTW'(-t4[j]) : MTW'(t4[j]);
      end
      for (int k = 0; k < NC; k++) begin
        sd4_q[k] <= ds[k][DW-1];
        md4_q[k] <= ds[k][DW-1] ? DW'(-ds[k]) : DW'(ds[k]);
      end
      for (int k = 0; k < 4; k++) begin
        base4_q[k] <= cs[k];
        base5_q[k] <= base4_q[k];
      end
      deg4_q <= (len[0] == '0) | (len[1] == '0) | (len[2] == '0);
      deg5_q <= deg4_q;
      // ab and ca use the tangent from a, bc the tangent from b
      for (int k = 0; k < NC; k++) begin
        num5_q[k] <= NW'(md4_q[k] * mt4_q[(k == 2 || k == 3) ? 1 : 0])
                   + NW'(len4_q[k / 2]);
        neg5_q[k] <= sd4_q[k] ^ st4_q[(k == 2 || k == 3) ? 1 : 0];
      end
    end
  end

  // dividers, with signs, bases and the degenerate flag delayed alongside
  logic [QB-1:0]    quo [NC];
  logic [DVL_W-1:0] dvl_in;
  logic [DVL_W-1:0] dvl_q [QB];

  for (genvar k = 0; k < NC; k++) begin : g_div
    tict_div #(
      .NUM_W (NW),
      .DEN_W (DENW),
      .QUO_W (QB)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num5_q[k]),
      .den_i (den5_q[k / 2]),
      .quo_o (quo[k])
    );
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dvl_in[k*CW +: CW] = base5_q[k];
    end
    for (int k = 0; k < NC; k++) begin
      dvl_in[4*CW + k] = neg5_q[k];
    end
    dvl_in[DVL_W-1] = deg5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvl_q[0] <= dvl_in;
      for (int k = 1; k < QB; k++) begin
        dvl_q[k] <= dvl_q[k-1];
      end
    end
  end

  // stage 6: add to vertex and clamp
  localparam logic signed [SW-1:0] HI = SW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);

  logic signed [SW-1:0] delta [NC];
  logic signed [SW-1:0] sum6  [NC];
  logic signed [CW-1:0] res_d [NC];
  logic signed [CW-1:0] res6_q [NC];
  logic                 st6_q;
  logic                 deg_o;

  assign deg_o = dvl_q[QB-1][DVL_W-1];

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      delta[k] = dvl_q[QB-1][4*CW + k] ? -SW'(quo[k]) : SW'(quo[k]);
      sum6[k]  = SW'(signed'(dvl_q[QB-1][((k < 4) ? k : k - 4)*CW +: CW])) + delta[k];
      if (deg_o) begin
        res_d[k] = '0;
      end else if (sum6[k] > HI) begin
        res_d[k] = CW'(HI);
      end else if (sum6[k] < LO) begin
        res_d[k] = CW'(LO);
      end else begin
        res_d[k] = CW'(sum6[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NC; k++) begin
        res6_q[k] <= res_d[k];
      end
      st6_q <= deg_o;
    end
  end

  logic [NC*CW-1:0] out_pack;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      out_pack[k*CW +: CW] = res6_q[k];
    end
  end

  assign m_axis_tdata_o = $bits(m_axis_tdata_o)'(out_pack);
  assign m_axis_tuser_o = st6_q;

endmodule

FILE: tb/tb_top.sv
// self-checking bench for triangle_incircle_touch_points: directed and random triangles
// predicts touch points with a behavioral model of the pipeline; depends on tict_pkg

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = 24;
  localparam int unsigned DW = ((6*CW+7)/8)*8;
  localparam int unsigned LATENCY = 65;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    coord_t cy, cx, by_coord, bx, ay, ax;
  } tri_t;
  typedef struct packed {
    logic degenerate;
    coord_t ca_y, ca_x, bc_y, bc_x, ab_y, ab_x;
  } touch_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o;
  logic [DW-1:0] s_axis_tdata_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [DW-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  touch_t expected_touch_q[$];
  int unsigned mismatch_cnt;
  int unsigned idle_cycles;
  bit hold_off;
  bit timed_out;

  triangle_incircle_touch_points #(.COORD_WIDTH(CW)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] guarded_len(longint dx, longint dy);
    logic [63:0] mx, my;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    return root64((mx*mx + my*my) << (2*tict_pkg::GUARD));
  endfunction

  // base + round(d*t/(2*len)) with halves away from zero, clamped to the coordinate range
  function automatic coord_t offset_point(longint base, longint d, longint t,
                                          logic [63:0] len);
    logic [63:0] num, q;
    longint v, hi, lo;
    num = (d < 0 ? -d : d) * (t < 0 ? -t : t);
    q = (num + len) / (2*len);
    if (q > 64'h7fff_ffff_ffff_ffff) q = 64'h7fff_ffff_ffff_ffff;
    v = ((d < 0) != (t < 0)) ? -longint'(q) : longint'(q);
    hi = (longint'(1) << (CW-1)) - 1;
    lo = -hi - 1;
    if (v > hi - base) v = hi;
    else if (v < lo - base) v = lo;
    else v = base + v;
    return coord_t'(v);
  endfunction

  function automatic touch_t incircle_touch(tri_t tr);
    longint ax, ay, bx, by, cx, cy, ta, tb;
    logic [63:0] lab, lbc, lca;
    touch_t r;
    ax = tr.ax; ay = tr.ay; bx = tr.bx; by = tr.by_coord; cx = tr.cx; cy = tr.cy;
    lab = guarded_len(bx-ax, by-ay);
    lbc = guarded_len(cx-bx, cy-by);
    lca = guarded_len(cx-ax, cy-ay);
    r = '0;
    if (lab == 0 || lbc == 0 || lca == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    ta = longint'(lab) + longint'(lca) - longint'(lbc);
    tb = longint'(lab) + longint'(lbc) - longint'(lca);
    r.ab_x = offset_point(ax, bx-ax, ta, lab);
    r.ab_y = offset_point(ay, by-ay, ta, lab);
    r.bc_x = offset_point(bx, cx-bx, tb, lbc);
    r.bc_y = offset_point(by, cy-by, tb, lbc);
    r.ca_x = offset_point(ax, cx-ax, ta, lca);
    r.ca_y = offset_point(ay, cy-ay, ta, lca);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    mismatch_cnt++;
  endtask

  task automatic send_triangle(tri_t tr);
    int unsigned gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= DW'(tr);
    expected_touch_q.push_back(incircle_touch(tr));
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // receiver side: random stall per transfer, or a long hold-off on request
  initial begin
    int unsigned gap;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
        repeat (1500) @(posedge clk_i);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    touch_t got, exp;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tuser_o, m_axis_tdata_o[6*CW-1:0]};
      if (expected_touch_q.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        exp = expected_touch_q.pop_front();
        if (got.ab_x != exp.ab_x) report_mismatch("touch_ab_x", got.ab_x, exp.ab_x);
        if (got.ab_y != exp.ab_y) report_mismatch("touch_ab_y", got.ab_y, exp.ab_y);
        if (got.bc_x != exp.bc_x) report_mismatch("touch_bc_x", got.bc_x, exp.bc_x);
        if (got.bc_y != exp.bc_y) report_mismatch("touch_bc_y", got.bc_y, exp.bc_y);
        if (got.ca_x != exp.ca_x) report_mismatch("touch_ca_x", got.ca_x, exp.ca_x);
        if (got.ca_y != exp.ca_y) report_mismatch("touch_ca_y", got.ca_y, exp.ca_y);
        if (got.degenerate != exp.degenerate)
          report_mismatch("status", got.degenerate, exp.degenerate);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("triangle_incircle_touch_points test failed");
      $finish;
    end
  end

  function automatic coord_t rand_coord(int unsigned range_sel);
    case (range_sel)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
      2: return $urandom_range(0, 1) ? coord_t'(24'h7fffff) : coord_t'(24'h800000);
      default: return coord_t'($urandom_range(0, 131071)) - coord_t'(65536);
    endcase
  endfunction

  function automatic tri_t random_triangle();
    tri_t tr;
    int unsigned sel, kind;
    sel = $urandom_range(0, 3);
    kind = $urandom_range(0, 19);
    tr.ax = rand_coord(sel); tr.ay = rand_coord(sel);
    tr.bx = rand_coord(sel); tr.by_coord = rand_coord(sel);
    tr.cx = rand_coord(sel); tr.cy = rand_coord(sel);
    if (kind == 0) begin
      tr.bx = tr.ax; tr.by_coord = tr.ay;
    end else if (kind == 1) begin
      tr.cx = tr.bx; tr.cy = tr.by_coord;
    end else if (kind == 2) begin
      // collinear unless it wraps: C = A + 2*(B - A)
      tr.cx = tr.ax + 2*(tr.bx - tr.ax);
      tr.cy = tr.ay + 2*(tr.by_coord - tr.ay);
    end
    return tr;
  endfunction

  function automatic tri_t make_tri(int a, int b, int c, int d, int e, int f);
    tri_t tr;
    tr.ax = coord_t'(a); tr.ay = coord_t'(b); tr.bx = coord_t'(c);
    tr.by_coord = coord_t'(d); tr.cx = coord_t'(e); tr.cy = coord_t'(f);
    return tr;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_touch_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic test_directed();
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    send_triangle(make_tri(0, 0, 768, 0, 0, 1024));
    send_triangle(make_tri(0, 0, 0, 0, 0, 0));
    send_triangle(make_tri(5, 5, 5, 5, 100, 7));
    send_triangle(make_tri(5, 5, 100, 7, 100, 7));
    send_triangle(make_tri(5, 5, 100, 7, 5, 5));
    send_triangle(make_tri(0, 0, 100, 100, 200, 200));
    send_triangle(make_tri(0, 0, 1, 0, 2, 0));
    send_triangle(make_tri(mn, mn, mx, mn, mn, mx));
    send_triangle(make_tri(mx, mx, mn, mx, mx, mn));
    send_triangle(make_tri(mn, mn, mx, mx, mn, mx));
    send_triangle(make_tri(mn, 0, mx, 0, 0, mx));
    send_triangle(make_tri(mx, mn, mn, mx, mx, mx));
    send_triangle(make_tri(-1, -1, 1, -1, 0, 1));
    send_triangle(make_tri(0, 0, 1, 0, 0, 1));
    send_triangle(make_tri(mn, mn, mx, mx, 0, 1));
    send_triangle(make_tri(-2560, 300, 4096, -77, 12, 9000));
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) send_triangle(random_triangle());
  endtask

  // receiver holds off while the sender keeps offering, then sender waits for drain
  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (200) send_triangle(random_triangle());
    wait_drained();
  endtask

  initial begin
    mismatch_cnt = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    timed_out = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(900);
    test_backpressure();
    test_random(900);
    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("triangle_incircle_touch_points test passed");
    end else begin
      $display("triangle_incircle_touch_points test failed");
    end
    $finish;
  end

endmodule
